// File: design/assert_macros.svh
// Assertion macros shared by the packet ring FEC retransmit RTL.
// Define NO_ASSERTIONS to compile every use down to nothing.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// cond holds at every clock edge outside reset
`define ASSERT_ALWAYS(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (cond)) \
        else $error("assertion failed");
// cons holds in the same cycle as ante
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");
// cons holds in the cycle after ante
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define ASSERT_ALWAYS(label, clk, rst_n, cond)
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons)
`define ASSERT_NEXT(label, clk, rst_n, ante, cons)
`endif
`endif

// File: design/prfr_pkg.sv
// Shared constants and types of the packet ring FEC retransmit block.
// No dependencies; used by prfr_mod_unit, packet_ring_fec_retransmit and the testbench.
package prfr_pkg;

    // RING_DEPTH must be a power of two: the slot is the low sequence bits.
    localparam int RING_DEPTH      = 4096;
    localparam int FRAME_WORDS     = 20;
    localparam int FEC_SKIP_PERIOD = 7;

    localparam int SLOT_W = $clog2(RING_DEPTH);
    localparam int ADDR_W = $clog2(RING_DEPTH * FRAME_WORDS);
    localparam int WPOS_W = (FRAME_WORDS > 1) ? $clog2(FRAME_WORDS) : 1;
    localparam int REM_W  = (FEC_SKIP_PERIOD > 2) ? $clog2(FEC_SKIP_PERIOD) : 1;

    localparam logic [31:0] PARITY_FLAG = 32'h8000_0000;

    typedef logic [SLOT_W-1:0] t_slot;
    typedef logic [ADDR_W-1:0] t_addr;
    typedef logic [WPOS_W-1:0] t_wpos;

    typedef enum logic {
        ACT_WORD = 1'b0,
        ACT_NACK = 1'b1
    } t_action;

    typedef enum logic {
        KIND_DATA   = 1'b0,
        KIND_PARITY = 1'b1
    } t_kind;

    typedef struct packed {
        logic        valid;
        logic [31:0] tag;
    } t_tag_entry;

    // status of the sequence-number remainder unit
    typedef struct packed {
        logic busy;
        logic zero;
    } t_mod_status;

endpackage

// File: design/prfr_mod_unit.sv
// Remainder of a 32-bit sequence number by FEC_SKIP_PERIOD, one hex digit per cycle.
// Depends on prfr_pkg.
module prfr_mod_unit (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic [31:0]           i_value,
    output prfr_pkg::t_mod_status o_status
);
    import prfr_pkg::*;

    localparam int DIGITS = 32 / 4;
    localparam int CNT_W  = $clog2(DIGITS);
    localparam int FOLD_W = REM_W + 4;

    localparam logic [FOLD_W-1:0] P1 = FOLD_W'(FEC_SKIP_PERIOD);
    localparam logic [FOLD_W-1:0] P2 = FOLD_W'(FEC_SKIP_PERIOD * 2);
    localparam logic [FOLD_W-1:0] P4 = FOLD_W'(FEC_SKIP_PERIOD * 4);
    localparam logic [FOLD_W-1:0] P8 = FOLD_W'(FEC_SKIP_PERIOD * 8);

    logic             r_busy;
    logic [CNT_W-1:0] r_cnt;
    logic [REM_W-1:0] r_rem;
    logic [31:0]      r_val;
    logic [REM_W-1:0] n_rem;
    logic [FOLD_W-1:0] fold;

    // rem*16 + digit stays below 16*P, so four restoring steps finish it
    always_comb begin
        fold = {r_rem, r_val[31:28]};
        if (fold >= P8) fold = fold - P8;
        if (fold >= P4) fold = fold - P4;
        if (fold >= P2) fold = fold - P2;
        if (fold >= P1) fold = fold - P1;
        n_rem = fold[REM_W-1:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= r_cnt + CNT_W'(1);
            if (r_cnt == CNT_W'(DIGITS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val <= i_value;
            r_rem <= '0;
        end else if (r_busy) begin
            r_val <= {r_val[27:0], 4'h0};
            r_rem <= n_rem;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.zero = (r_rem == '0);

endmodule

// File: design/packet_ring_fec_retransmit.sv
// Top level of the packet ring FEC retransmit block: frame ring, tag ring, packet sequencer.
// Depends on prfr_pkg, prfr_mod_unit and assert_macros.svh.
//
// Usage:
//   Input channel (i_in_valid / o_in_ready) carries one word per handshake: a frame
//   payload word (i_action = 0) or a NACK (i_action = 1). Output channel
//   (o_out_valid / i_out_ready) carries one outgoing packet word per handshake;
//   o_run_end marks the last word caused by one input word.
//   Payload words that do not end a frame are taken back to back. A frame's last word
//   or a NACK goes through the tag lookup and the S_TAG state, then one output word
//   per cycle follows while the receiver is ready: 20 for a data packet, 40 for frame
//   0 or for data plus parity; a NACK whose tag misses yields none. The first output
//   word passes the read stage and the output register. Throughput is set by the
//   single read sequencer on the frame memory: one packet word per cycle. Parity
//   eligibility comes from a remainder unit that runs under the first data packet.
//   Reset: a clearing pass walks the 4096 tag entries, one a cycle, dropping all
//   valid bits; o_in_ready stays low until the pass ends.
//   Receiver stall: a two-deep output pipe holds words and the sequencer stops
//   issuing memory reads; nothing is lost or repeated. The block accepts new
//   input words as soon as the last read of the current run has been issued.
`include "assert_macros.svh"

module packet_ring_fec_retransmit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic        i_action,
    input  logic [31:0] i_seq_number,
    input  logic [63:0] i_payload_word,
    input  logic        i_word_last,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic        o_packet_kind,
    output logic [31:0] o_header_word,
    output logic [63:0] o_out_payload,
    output logic        o_packet_end,
    output logic        o_run_end
);
    import prfr_pkg::*;

    typedef enum logic [3:0] {
        S_CLEAR = 4'b0001,   // post-reset sweep of the tag ring
        S_IDLE  = 4'b0010,   // taking input words
        S_TAG   = 4'b0100,   // tag lookup result available
        S_EMIT  = 4'b1000    // streaming packet words out of the frame ring
    } t_state;

    // ---------------- control state ----------------
    t_state      r_state;
    t_slot       r_clr_cnt;
    t_wpos       r_wpos;      // word position inside the frame being received
    t_wpos       r_word;      // word being read in the current packet
    logic        r_first;     // first packet of the run (does the zero fill)
    logic        r_rep;       // frame 0: second data packet still due
    logic        r_par_chk;   // previous frame present: parity depends on remainder
    t_kind       r_kind;
    logic        r_s1_vld;
    logic        r_out_vld;

    // ---------------- per-run payload ----------------
    logic [31:0] r_seq;
    logic [31:0] r_cmp;       // tag expected in the looked-up slot
    logic        r_nack;
    t_addr       r_base_a;    // current slot base
    t_addr       r_base_b;    // previous slot base
    t_wpos       r_pos;       // last written word; later words read as zero

    // ---------------- memories ----------------
    t_tag_entry  r_tag_mem [RING_DEPTH];
    t_tag_entry  r_tag_rd;
    logic [63:0] r_frame_mem [RING_DEPTH * FRAME_WORDS];
    logic [63:0] r_rd_a;
    logic [63:0] r_rd_b;

    // ---------------- read stage and output register ----------------
    t_kind       r_s1_kind;
    logic [31:0] r_s1_hdr;
    logic        r_s1_end;
    logic        r_s1_run;
    logic        r_s1_zero;
    logic        r_s1_xor;

    t_kind       r_out_kind;
    logic [31:0] r_out_hdr;
    logic [63:0] r_out_pay;
    logic        r_out_end;
    logic        r_out_run;

    t_mod_status mod_st;

    // ---------------- combinational ----------------
    logic        accept;
    logic        is_word;
    logic        is_last;
    logic        is_nack;
    t_slot       in_slot;
    logic [31:0] seq_m1;
    t_slot       prev_slot;
    logic        tag_match;
    logic        out_adv;
    logic        s1_move;
    logic        s1_free;
    logic        word_final;
    logic        hold;
    logic        issue;
    logic        more;
    logic        zero_now;
    logic        fm_we;
    t_addr       fm_waddr;
    logic [63:0] fm_wdata;
    t_addr       rd_addr_a;
    t_addr       rd_addr_b;
    logic        tm_we;
    t_slot       tm_waddr;
    t_tag_entry  tm_wdata;
    t_slot       tm_raddr;

    function automatic t_addr frame_base(input t_slot slot);
        return t_addr'(t_addr'(slot) * t_addr'(FRAME_WORDS));
    endfunction

    assign o_in_ready = (r_state == S_IDLE);
    assign accept     = i_in_valid && o_in_ready;
    assign is_word    = accept && (i_action == ACT_WORD);
    assign is_last    = is_word && i_word_last;
    assign is_nack    = accept && (i_action == ACT_NACK);

    assign in_slot    = i_seq_number[SLOT_W-1:0];
    assign seq_m1     = i_seq_number - 32'd1;
    assign prev_slot  = seq_m1[SLOT_W-1:0];

    assign tag_match  = r_tag_rd.valid && (r_tag_rd.tag == r_cmp);

    assign out_adv    = !r_out_vld || i_out_ready;
    assign s1_move    = r_s1_vld && out_adv;
    assign s1_free    = !r_s1_vld || out_adv;

    assign word_final = (r_word == t_wpos'(FRAME_WORDS - 1));
    // the final word of the last data packet waits for the parity decision
    assign hold       = word_final && !r_rep && r_par_chk && mod_st.busy;
    assign issue      = (r_state == S_EMIT) && s1_free && !hold;
    assign more       = r_rep || (r_par_chk && !mod_st.zero);
    // short frame: words past the last written one are zero-filled while read
    assign zero_now   = r_first && (r_word > r_pos);

    assign rd_addr_a  = r_base_a + t_addr'(r_word);
    assign rd_addr_b  = r_base_b + t_addr'(r_word);

    // frame ring write port: incoming words in IDLE, zero fill in EMIT
    always_comb begin
        fm_we    = is_word || (issue && zero_now);
        fm_waddr = rd_addr_a;
        fm_wdata = '0;
        if (is_word) begin
            fm_waddr = frame_base(in_slot) + t_addr'(r_wpos);
            fm_wdata = i_payload_word;
        end
    end

    // tag ring: clear pass zeroes it; any payload word drops the valid bit, the last sets it
    always_comb begin
        tm_we    = (r_state == S_CLEAR) || is_word;
        tm_waddr = in_slot;
        tm_wdata = '{valid: i_word_last, tag: i_seq_number};
        if (r_state == S_CLEAR) begin
            tm_waddr = r_clr_cnt;
            tm_wdata = '0;
        end
        tm_raddr = is_last ? prev_slot : in_slot;
    end

    always_ff @(posedge i_clk) begin
        if (fm_we) begin
            r_frame_mem[fm_waddr] <= fm_wdata;
        end
        if (issue) begin
            r_rd_a <= r_frame_mem[rd_addr_a];
            r_rd_b <= r_frame_mem[rd_addr_b];
        end
    end

    always_ff @(posedge i_clk) begin
        if (tm_we) begin
            r_tag_mem[tm_waddr] <= tm_wdata;
        end
        if (accept) begin
            r_tag_rd <= r_tag_mem[tm_raddr];
        end
    end

    prfr_mod_unit u_mod (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (is_last),
        .i_value  (i_seq_number),
        .o_status (mod_st)
    );

    // ---------------- sequencer ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_CLEAR;
            r_clr_cnt <= '0;
            r_wpos    <= '0;
            r_word    <= '0;
            r_first   <= 1'b0;
            r_rep     <= 1'b0;
            r_par_chk <= 1'b0;
            r_kind    <= KIND_DATA;
        end else begin
            unique case (r_state)
                S_CLEAR: begin
                    r_clr_cnt <= r_clr_cnt + t_slot'(1);
                    if (r_clr_cnt == t_slot'(RING_DEPTH - 1)) begin
                        r_state <= S_IDLE;
                    end
                end
                S_IDLE: begin
                    r_word    <= '0;
                    r_first   <= 1'b1;
                    r_kind    <= KIND_DATA;
                    r_par_chk <= 1'b0;
                    r_rep     <= is_last && (i_seq_number == 32'd0);
                    if (is_word) begin
                        if (i_word_last) begin
                            r_wpos  <= '0;
                            r_state <= S_TAG;
                        end else if (r_wpos < t_wpos'(FRAME_WORDS - 1)) begin
                            r_wpos <= r_wpos + t_wpos'(1);
                        end
                    end
                    if (is_nack) begin
                        r_state <= S_TAG;
                    end
                end
                S_TAG: begin
                    if (r_nack) begin
                        r_state <= tag_match ? S_EMIT : S_IDLE;
                    end else begin
                        r_par_chk <= tag_match;
                        r_state   <= S_EMIT;
                    end
                end
                S_EMIT: begin
                    if (issue) begin
                        if (!word_final) begin
                            r_word <= r_word + t_wpos'(1);
                        end else if (r_rep) begin
                            r_rep   <= 1'b0;
                            r_word  <= '0;
                            r_first <= 1'b0;
                        end else if (r_par_chk && !mod_st.zero) begin
                            r_par_chk <= 1'b0;
                            r_kind    <= KIND_PARITY;
                            r_word    <= '0;
                            r_first   <= 1'b0;
                        end else begin
                            r_par_chk <= 1'b0;
                            r_state   <= S_IDLE;
                        end
                    end
                end
                default: r_state <= S_CLEAR;
            endcase
        end
    end

    // per-run context captured with the input word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_seq    <= i_seq_number;
            r_nack   <= (i_action == ACT_NACK);
            r_cmp    <= (i_action == ACT_NACK) ? i_seq_number : seq_m1;
            r_base_a <= frame_base(in_slot);
            r_base_b <= frame_base(prev_slot);
            r_pos    <= (i_action == ACT_NACK) ? t_wpos'(FRAME_WORDS - 1) : r_wpos;
        end
    end

    // ---------------- read stage / output register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            if (issue) begin
                r_s1_vld <= 1'b1;
            end else if (s1_move) begin
                r_s1_vld <= 1'b0;
            end
            if (out_adv) begin
                r_out_vld <= r_s1_vld;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (issue) begin
            r_s1_kind <= r_kind;
            r_s1_hdr  <= r_seq | ((r_kind == KIND_PARITY) ? PARITY_FLAG : 32'd0);
            r_s1_end  <= word_final;
            r_s1_run  <= word_final && !more;
            r_s1_zero <= zero_now;
            r_s1_xor  <= (r_kind == KIND_PARITY);
        end
        if (s1_move) begin
            r_out_kind <= r_s1_kind;
            r_out_hdr  <= r_s1_hdr;
            r_out_pay  <= (r_s1_zero ? 64'd0 : r_rd_a) ^ (r_s1_xor ? r_rd_b : 64'd0);
            r_out_end  <= r_s1_end;
            r_out_run  <= r_s1_run;
        end
    end

    assign o_out_valid   = r_out_vld;
    assign o_packet_kind = r_out_kind;
    assign o_header_word = r_out_hdr;
    assign o_out_payload = r_out_pay;
    assign o_packet_end  = r_out_end;
    assign o_run_end     = r_out_run;

    // ---------------- assertions ----------------
    `ASSERT_NEXT(a_rd_hold, i_clk, i_rst_n, r_s1_vld && !out_adv, $stable(r_rd_a) && $stable(r_s1_hdr))
    `ASSERT_IMPLIES(a_run_end_closes_packet, i_clk, i_rst_n, o_out_valid && o_run_end, o_packet_end)
    `ASSERT_IMPLIES(a_clear_quiet, i_clk, i_rst_n, r_state == S_CLEAR, !r_s1_vld && !r_out_vld && !mod_st.busy)
    `ASSERT_ALWAYS(a_wpos_range, i_clk, i_rst_n, r_wpos <= t_wpos'(FRAME_WORDS - 1))

endmodule

// File: dv/testbench.sv
// Self-checking testbench for packet_ring_fec_retransmit: frame and NACK words in,
// data and XOR parity packet words out, compared against an in-bench ring model.
// Depends on prfr_pkg and the packet_ring_fec_retransmit RTL.
module testbench;
    timeunit 1ns;
    timeprecision 1ps;

    import prfr_pkg::*;

    localparam int unsigned RANDOM_ITEMS = 110;
    localparam int unsigned CALM_AFTER   = 85;      // random words before idling stops
    localparam int unsigned PAUSE_AFTER  = 50;      // random words before the drain pause
    localparam int unsigned DRAIN_CYCLES = 50;
    localparam int unsigned CYCLE_LIMIT  = 1_000_000;

    // one expected outgoing packet word
    typedef struct {
        t_kind       kind;
        logic [31:0] header;
        logic [63:0] payload;
        logic        pkt_end;
        logic        run_end;
    } t_pkt_word;

    // Ring model plus the queue of packet words it still expects.
    class fec_tracker;
        logic [63:0] ring_mem [int];            // absent key = never written
        logic [31:0] slot_tag [RING_DEPTH];
        bit          slot_live [RING_DEPTH];
        logic [4:0]  fill_pos = '0;
        t_pkt_word   pending_words [$];
        int          errors = 0;

        function int addr_of(t_slot slot, int unsigned w);
            return int'(slot) * FRAME_WORDS + int'(w);
        endfunction

        // queue one whole packet read from the ring
        function void queue_packet(t_kind kind, logic [31:0] hdr, t_slot slot,
                                   bit with_parity, t_slot pslot);
            logic [63:0] v;
            for (int w = 0; w < FRAME_WORDS; w++) begin
                v = ring_mem[addr_of(slot, w)];
                if (with_parity)
                    v ^= ring_mem[addr_of(pslot, w)];
                pending_words.push_back('{kind, hdr, v, w == FRAME_WORDS - 1, 1'b0});
            end
        endfunction

        // accepted input word: update the ring and predict what it sends
        function void note_input(t_action act, logic [31:0] seq, logic [63:0] data,
                                 logic last);
            t_slot       slot;
            t_slot       prev_slot;
            logic [31:0] prev_seq;
            int unsigned pos;
            int          start_size;
            slot       = seq[SLOT_W-1:0];
            start_size = pending_words.size();
            if (act == ACT_NACK) begin
                if (slot_live[slot] && slot_tag[slot] == seq)
                    queue_packet(KIND_DATA, seq, slot, 1'b0, slot);
            end else begin
                // overlong frames keep rewriting the final word
                pos = (fill_pos > FRAME_WORDS - 1) ? FRAME_WORDS - 1 : fill_pos;
                ring_mem[addr_of(slot, pos)] = data;
                slot_live[slot] = 1'b0;
                if (!last) begin
                    if (pos < FRAME_WORDS - 1)
                        pos++;
                    fill_pos = 5'(pos);
                end else begin
                    // short frame: zero-fill the tail of the slot
                    for (int w = pos + 1; w < FRAME_WORDS; w++)
                        ring_mem[addr_of(slot, w)] = '0;
                    slot_tag[slot]  = seq;
                    slot_live[slot] = 1'b1;
                    fill_pos        = '0;
                    queue_packet(KIND_DATA, seq, slot, 1'b0, slot);
                    if (seq == 0)
                        queue_packet(KIND_DATA, seq, slot, 1'b0, slot);
                    if (seq != 0 && !(seq >= FEC_SKIP_PERIOD && seq % FEC_SKIP_PERIOD == 0))
                    begin
                        prev_seq  = seq - 1;
                        prev_slot = prev_seq[SLOT_W-1:0];
                        if (slot_live[prev_slot] && slot_tag[prev_slot] == prev_seq)
                            queue_packet(KIND_PARITY, seq | PARITY_FLAG, slot, 1'b1, prev_slot);
                    end
                end
            end
            if (pending_words.size() > start_size)
                pending_words[pending_words.size() - 1].run_end = 1'b1;
        endfunction

        // accepted output word: compare against the oldest expectation
        function void check_output(logic kind, logic [31:0] header, logic [63:0] payload,
                                   logic pkt_end, logic run_end);
            t_pkt_word exp_word;
            if (pending_words.size() == 0) begin
                $error("unexpected output word: header %h payload %h", header, payload);
                errors++;
                return;
            end
            exp_word = pending_words.pop_front();
            if (kind !== exp_word.kind) begin
                $error("packet_kind: expected %0d, got %0d", exp_word.kind, kind);
                errors++;
            end
            if (header !== exp_word.header) begin
                $error("header_word: expected %h, got %h", exp_word.header, header);
                errors++;
            end
            if (payload !== exp_word.payload) begin
                $error("out_payload: expected %h, got %h", exp_word.payload, payload);
                errors++;
            end
            if (pkt_end !== exp_word.pkt_end) begin
                $error("packet_end: expected %0d, got %0d", exp_word.pkt_end, pkt_end);
                errors++;
            end
            if (run_end !== exp_word.run_end) begin
                $error("run_end: expected %0d, got %0d", exp_word.run_end, run_end);
                errors++;
            end
        endfunction
    endclass

    logic        i_clk          = 1'b0;
    logic        i_rst_n        = 1'b0;
    logic        i_in_valid     = 1'b0;
    logic        o_in_ready;
    logic        i_action       = 1'b0;
    logic [31:0] i_seq_number   = '0;
    logic [63:0] i_payload_word = '0;
    logic        i_word_last    = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready    = 1'b0;
    logic        o_packet_kind;
    logic [31:0] o_header_word;
    logic [63:0] o_out_payload;
    logic        o_packet_end;
    logic        o_run_end;

    fec_tracker  sb = new;
    logic [31:0] finished_seqs [$];             // seqs whose slot was completed once
    int unsigned items_sent  = 0;
    int unsigned stall_left  = 0;
    int unsigned cycle_count = 0;
    bit          calm        = 1'b0;            // no idling on either side once set

    packet_ring_fec_retransmit u_dut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_action       (i_action),
        .i_seq_number   (i_seq_number),
        .i_payload_word (i_payload_word),
        .i_word_last    (i_word_last),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_packet_kind  (o_packet_kind),
        .o_header_word  (o_header_word),
        .o_out_payload  (o_out_payload),
        .o_packet_end   (o_packet_end),
        .o_run_end      (o_run_end)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Hard stop: covers the tag clear pass plus worst-case stalls many times over.
    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("testbench failed");
            $finish;
        end
    end

    // Receiver: ready drops in random bursts until the calm phase.
    always @(posedge i_clk) begin
        if (stall_left != 0) begin
            stall_left  <= stall_left - 1;
            i_out_ready <= 1'b0;
        end else if (!calm && $urandom_range(0, 7) == 0) begin
            stall_left  <= $urandom_range(0, 14);
            i_out_ready <= 1'b0;
        end else begin
            i_out_ready <= 1'b1;
        end
    end

    // Output monitor: values seen here are the ones present before this edge.
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready)
            sb.check_output(o_packet_kind, o_header_word, o_out_payload,
                            o_packet_end, o_run_end);
    end

    // Send one input word; valid stays high on return so back-to-back words
    // never lower and raise it in the same step.
    task automatic send_word(t_action act, logic [31:0] seq, logic [63:0] data,
                             logic last);
        if (!calm && $urandom_range(0, 4) == 0) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 15)) @(posedge i_clk);
        end
        i_in_valid     <= 1'b1;
        i_action       <= act;
        i_seq_number   <= seq;
        i_payload_word <= data;
        i_word_last    <= last;
        do @(posedge i_clk); while (!o_in_ready);
        sb.note_input(act, seq, data, last);
        items_sent++;
        if (act == ACT_WORD && last)
            finished_seqs.push_back(seq);
    endtask

    // Drop valid and hold off until every expected word has come out.
    task automatic hold_until_drained();
        i_in_valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending_words.size() != 0);
    endtask

    // Frame of len words with random content. A word may stray to another seq
    // only where the frame's own slot already holds data at that position, so
    // the finished slot never carries an unwritten word.
    task automatic send_frame(logic [31:0] seq, int unsigned len, bit closed);
        logic [31:0] word_seq;
        logic [63:0] data;
        int unsigned p;
        for (int unsigned i = 0; i < len; i++) begin
            word_seq = seq;
            p = (sb.fill_pos > FRAME_WORDS - 1) ? FRAME_WORDS - 1 : sb.fill_pos;
            if (i + 1 < len && $urandom_range(0, 9) == 0 &&
                sb.ring_mem.exists(sb.addr_of(seq[SLOT_W-1:0], p)))
                word_seq = $urandom;
            case ($urandom_range(0, 7))
                0:       data = '0;
                1:       data = '1;
                default: data = {$urandom, $urandom};
            endcase
            send_word(ACT_WORD, word_seq, data, closed && i + 1 == len);
        end
    endtask

    initial begin
        logic [31:0] seq;
        logic [31:0] next_seq;
        int unsigned len;
        int unsigned pick;
        int unsigned random_start;
        bit          paused;
        paused = 1'b0;

        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // ---- directed ----
        // frame 0, short: tail zero-filled, data packet sent twice
        send_word(ACT_WORD, 32'd0, '1, 1'b1);
        // frame 1: data plus parity against frame 0
        send_word(ACT_WORD, 32'd1, '0, 1'b0);
        send_word(ACT_WORD, 32'd1, 64'h0123_4567_89ab_cdef, 1'b1);
        // NACK hit, NACK on tag mismatch, NACK on an empty slot
        send_word(ACT_NACK, 32'd1, '0, 1'b0);
        send_word(ACT_NACK, 32'd1 + RING_DEPTH, '1, 1'b1);
        send_word(ACT_NACK, 32'd5, '0, 1'b0);
        // seq 7 is a skip-period multiple: no parity though slot 6 is live
        send_word(ACT_WORD, 32'd6, 64'hdead_beef_0000_ffff, 1'b1);
        send_word(ACT_WORD, 32'd7, 64'h8000_0000_0000_0001, 1'b1);
        // top of the seq range: header bit 31 on data, parity across the pair
        send_word(ACT_WORD, 32'hffff_fffe, 64'h5555_5555_5555_5555, 1'b1);
        send_word(ACT_WORD, 32'hffff_ffff, 64'haaaa_aaaa_aaaa_aaaa, 1'b1);
        // seq changes mid-frame: first word lands in slot 6 and kills it
        send_word(ACT_WORD, 32'd6, 64'hfeed_f00d_cafe_babe, 1'b0);
        send_word(ACT_WORD, 32'd1, 64'h1111_2222_3333_4444, 1'b1);
        send_word(ACT_NACK, 32'd6, '0, 1'b0);
        // NACK in the middle of a frame leaves the word position alone
        send_word(ACT_WORD, 32'd3, 64'h0f0f_0f0f_0f0f_0f0f, 1'b0);
        send_word(ACT_NACK, 32'd7, '0, 1'b0);
        send_word(ACT_WORD, 32'd3, 64'hf0f0_f0f0_f0f0_f0f0, 1'b1);
        // seq 8 pairs with live seq 7
        send_word(ACT_WORD, 32'd8, 64'h7fff_ffff_ffff_ffff, 1'b1);

        hold_until_drained();

        // ---- random ----
        random_start = items_sent;
        next_seq     = 32'd9;
        while (items_sent < random_start + RANDOM_ITEMS) begin
            if (items_sent >= random_start + CALM_AFTER)
                calm <= 1'b1;
            if (!paused && items_sent >= random_start + PAUSE_AFTER) begin
                hold_until_drained();
                paused = 1'b1;
            end
            pick = $urandom_range(0, 99);
            if (pick < 85 && pick >= 65) begin
                // NACK: finished frames, some tag aliases and random seqs
                seq = finished_seqs[$urandom_range(0, finished_seqs.size() - 1)];
                case ($urandom_range(0, 9))
                    0, 1:    seq = seq + RING_DEPTH;
                    2, 3, 4: seq = $urandom;
                    default: ;
                endcase
                send_word(ACT_NACK, seq, {$urandom, $urandom}, 1'($urandom));
            end else begin
                // a word position left over from a cut-off frame means the
                // next frame must reuse a slot that is already fully written
                if (sb.fill_pos != 0) begin
                    seq = finished_seqs[$urandom_range(0, finished_seqs.size() - 1)];
                end else begin
                    case ($urandom_range(0, 19))
                        0, 1:    seq = $urandom;
                        2:       seq = '0;
                        3, 4:    seq = $urandom_range(1, 2000) * FEC_SKIP_PERIOD
                                       - $urandom_range(0, 2);
                        default: seq = next_seq;
                    endcase
                end
                case ($urandom_range(0, 15))
                    0:       len = $urandom_range(FRAME_WORDS + 1, FRAME_WORDS + 3);
                    1, 2:    len = $urandom_range(5, FRAME_WORDS);
                    default: len = $urandom_range(1, 4);
                endcase
                if (pick >= 85) begin
                    // cut-off frame: no last word
                    send_frame(seq, $urandom_range(1, 3), 1'b0);
                end else begin
                    send_frame(seq, len, 1'b1);
                    next_seq = seq + 1;
                end
            end
        end

        // ---- drain ----
        hold_until_drained();
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending_words.size() == 0)
            $display("testbench passed");
        else
            $display("testbench failed");
        $finish;
    end

endmodule

// File: filelist.f
+incdir+design
design/prfr_pkg.sv
design/prfr_mod_unit.sv
design/packet_ring_fec_retransmit.sv
dv/testbench.sv
